>>> rtl/lfu_pkg.sv
// Package: shared constants and types of the LFU cache table.
`default_nettype none
package lfu_pkg;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int HASH_BUCKETS_DEF = 16;
    localparam int VALUE_BITS_DEF = 64;
    localparam int KEY_W = 32;
    localparam int CNT_W = 32;
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_HIT   = 7'b0000100,
        ST_AGE   = 7'b0001000,
        ST_INS   = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_VSCAN = 7'b1000000
    } t_state;
endpackage
`default_nettype wire

>>> rtl/lfu_cache_table_core.sv
// Top level: LFU key/value cache with memory-held slots and a sequential scanner.
//
//  channel | signals                                       | direction
//  in      | i_valid, o_stall, i_cmd, i_lookup_key, i_write_value | into the block
//  out     | o_valid, i_stall, o_hit, o_read_value, o_entries_in_use | out of the block
//  cfg     | i_cfg_we, i_cfg_wdata (capacity_limit)        | into the block
//
// From acceptance to the output word, a get miss takes one key pass over the single read
// port of the slot memory; a hit adds a read-modify-write of the found slot. A put of a
// new key adds a rank pass; with the table full a victim pass and a rank-drop pass come
// first. Reset clears valid bits and occupancy at once. The input is stalled while an
// item is in work and while a finished word waits in the output register until taken.
`default_nettype none
module lfu_cache_table_core #(
    parameter int MAX_ENTRIES  = lfu_pkg::MAX_ENTRIES_DEF,
    parameter int HASH_BUCKETS = lfu_pkg::HASH_BUCKETS_DEF,
    parameter int VALUE_BITS   = lfu_pkg::VALUE_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_cmd,
    input  wire logic [31:0]              i_lookup_key,
    input  wire logic [63:0]              i_write_value,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic                          o_hit,
    output logic [63:0]                   o_read_value,
    output logic [lfu_pkg::CAP_W-1:0]     o_entries_in_use,
    input  wire logic                     i_cfg_we,
    input  wire logic [lfu_pkg::CAP_W-1:0] i_cfg_wdata
);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OW = $clog2(MAX_ENTRIES + 1);
    localparam int BW = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
    localparam int MW = lfu_pkg::KEY_W + VALUE_BITS + lfu_pkg::CNT_W + IW;
    localparam logic [IW:0] LAST = (IW+1)'(MAX_ENTRIES - 1);
    localparam logic [lfu_pkg::CNT_W-1:0] CMAX = '1;

    lfu_pkg::t_state r_st;
    logic [MW-1:0] mem [MAX_ENTRIES];
    logic [MW-1:0] r_rd;
    logic [MAX_ENTRIES-1:0] r_vld;
    logic [OW-1:0] r_occ;
    logic [lfu_pkg::CAP_W-1:0] r_cap;
    logic r_cmd;
    logic [31:0] r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [IW:0] r_ra;
    logic [IW-1:0] r_pa;
    logic r_pv;
    logic r_found;
    logic [IW-1:0] r_idx;
    logic r_vsel;
    logic [lfu_pkg::CNT_W-1:0] r_vcnt;
    logic [BW-1:0] r_vbkt;
    logic [IW-1:0] r_vrank;
    logic r_pass;
    logic r_ev;
    logic [IW-1:0] r_erank;
    logic [IW-1:0] r_free;
    logic r_ov;
    logic r_hit;
    logic [63:0] r_rv;

    logic we;
    logic [IW-1:0] wa;
    logic [MW-1:0] wd;
    logic [31:0] d_key;
    logic [VALUE_BITS-1:0] d_val;
    logic [lfu_pkg::CNT_W-1:0] d_cnt;
    logic [IW-1:0] d_rank;
    logic [BW-1:0] d_bkt;
    logic [lfu_pkg::CAP_W-1:0] ecap;
    logic full;
    logic better;
    logic [IW-1:0] ra_i;

    assign {d_key, d_val, d_cnt, d_rank} = r_rd;
    assign d_bkt = (HASH_BUCKETS > 1) ? BW'(d_key % HASH_BUCKETS) : '0;
    assign ra_i = r_ra[IW-1:0];
    assign ecap = (r_cap == '0) ? lfu_pkg::CAP_W'(1) :
                  (r_cap > lfu_pkg::CAP_W'(MAX_ENTRIES)) ? lfu_pkg::CAP_W'(MAX_ENTRIES) : r_cap;
    assign full = lfu_pkg::CAP_W'(r_occ) >= ecap;
    assign better = !r_vsel || d_cnt < r_vcnt ||
                    (d_cnt == r_vcnt && (d_bkt < r_vbkt ||
                    (d_bkt == r_vbkt && d_rank < r_vrank)));

    assign o_stall = (r_st != lfu_pkg::ST_IDLE) || r_ov;
    assign o_valid = r_ov;
    assign o_hit = r_hit;
    assign o_read_value = r_rv;
    assign o_entries_in_use = lfu_pkg::CAP_W'(r_occ);

    always_ff @(posedge i_clk) begin
        r_rd <= mem[ra_i];
        if (we) begin
            mem[wa] <= wd;
        end
    end

    always_comb begin
        we = 1'b0;
        wa = r_pa;
        wd = r_rd;
        case (r_st)
            lfu_pkg::ST_HIT: begin
                we = r_pv;
                wa = r_idx;
                wd = {d_key, (r_cmd == lfu_pkg::CMD_PUT) ? r_val : d_val,
                      (d_cnt == CMAX) ? d_cnt : d_cnt + 1'b1, d_rank};
            end
            lfu_pkg::ST_AGE: begin
                we = r_pv && r_vld[r_pa];
                wa = r_pa;
                if (r_ev && d_rank > r_erank) begin
                    wd = {d_key, d_val, d_cnt, d_rank - 1'b1};
                end
                if (!r_pass) begin
                    wd[IW-1:0] = (r_ev && d_rank > r_erank) ? d_rank : d_rank + 1'b1;
                end
            end
            lfu_pkg::ST_INS: begin
                we = 1'b1;
                wa = r_free;
                wd = {r_key, r_val, lfu_pkg::CNT_W'(1), IW'(0)};
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= lfu_pkg::ST_IDLE;
            r_vld <= '0;
            r_occ <= '0;
            r_cap <= lfu_pkg::CAP_RESET;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                lfu_pkg::ST_IDLE: begin
                    if (i_valid && !r_ov) begin
                        r_cmd <= i_cmd;
                        r_key <= i_lookup_key;
                        r_val <= i_write_value[VALUE_BITS-1:0];
                        r_ra <= '0;
                        r_pv <= 1'b0;
                        r_found <= 1'b0;
                        r_st <= lfu_pkg::ST_SCAN;
                    end
                end
                lfu_pkg::ST_SCAN: begin
                    r_pa <= ra_i;
                    r_pv <= (r_ra <= LAST);
                    r_ra <= r_ra + 1'b1;
                    if (r_pv && r_vld[r_pa] && d_key == r_key && !r_found) begin
                        r_found <= 1'b1;
                        r_idx <= r_pa;
                    end
                    if (!(r_ra <= LAST) && !r_pv) begin
                        if (r_found) begin
                            r_ra <= {1'b0, r_idx};
                            r_st <= lfu_pkg::ST_HIT;
                            r_pv <= 1'b0;
                        end else if (r_cmd == lfu_pkg::CMD_GET) begin
                            r_hit <= 1'b0;
                            r_rv <= '0;
                            r_st <= lfu_pkg::ST_OUT;
                        end else begin
                            r_ra <= '0;
                            r_pv <= 1'b0;
                            r_vsel <= 1'b0;
                            r_ev <= full;
                            r_st <= full ? lfu_pkg::ST_VSCAN : lfu_pkg::ST_AGE;
                            r_pass <= full;
                        end
                    end
                end
                lfu_pkg::ST_HIT: begin
                    if (!r_pv) begin
                        r_pv <= 1'b1;
                    end else begin
                        r_hit <= 1'b1;
                        r_rv <= (r_cmd == lfu_pkg::CMD_GET) ? 64'(d_val) : '0;
                        r_pv <= 1'b0;
                        r_st <= lfu_pkg::ST_OUT;
                    end
                end
                lfu_pkg::ST_VSCAN: begin
                    r_pa <= ra_i;
                    r_pv <= (r_ra <= LAST);
                    r_ra <= r_ra + 1'b1;
                    if (r_pv && r_vld[r_pa] && better) begin
                        r_vsel <= 1'b1;
                        r_idx <= r_pa;
                        r_vcnt <= d_cnt;
                        r_vbkt <= d_bkt;
                        r_vrank <= d_rank;
                    end
                    if (!(r_ra <= LAST) && !r_pv) begin
                        r_ra <= '0;
                        r_ev <= r_vsel;
                        r_erank <= r_vrank;
                        if (r_vsel) begin
                            r_vld[r_idx] <= 1'b0;
                            r_occ <= r_occ - 1'b1;
                        end
                        r_st <= lfu_pkg::ST_AGE;
                    end
                end
                lfu_pkg::ST_AGE: begin
                    r_pa <= ra_i;
                    r_pv <= (r_ra <= LAST);
                    r_ra <= r_ra + 1'b1;
                    if (!(r_ra <= LAST) && !r_pv) begin
                        r_ra <= '0;
                        if (r_pass) begin
                            r_pass <= 1'b0;
                            r_ev <= 1'b0;
                        end else begin
                            r_st <= lfu_pkg::ST_INS;
                            for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
                                if (!r_vld[i]) begin
                                    r_free <= IW'(i);
                                end
                            end
                        end
                    end
                end
                lfu_pkg::ST_INS: begin
                    r_vld[r_free] <= 1'b1;
                    r_occ <= r_occ + 1'b1;
                    r_hit <= 1'b0;
                    r_rv <= '0;
                    r_st <= lfu_pkg::ST_OUT;
                end
                lfu_pkg::ST_OUT: begin
                    if (!r_ov || !i_stall) begin
                        r_ov <= 1'b1;
                        r_st <= lfu_pkg::ST_IDLE;
                    end
                end
                default: r_st <= lfu_pkg::ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
